### design/ccp_pkg.sv
// Package for the three-point circumcentre core: widths, types and constants.
// Used by every module of the block; depends on nothing else.
package ccp_pkg;

    localparam int CW   = 32;            // coordinate width, signed Q16.16
    localparam int DW   = CW + 1;        // difference of two coordinates
    localparam int PW   = 2 * DW;        // product of two differences
    localparam int PPW  = 2 * DW + 1;    // difference times one half of a square sum
    localparam int DETW = PW + 2;        // twice the determinant
    localparam int NW   = DW + PW + 1;   // bisector numerator
    localparam int QB   = CW + 2;        // quotient bits produced by the divider
    localparam int RW   = DETW;          // divider remainder and divisor
    localparam int QW   = QB + 2;        // signed, rounded quotient
    localparam int SW   = QW + 1;        // centre before clamping

    typedef logic signed [CW-1:0]   t_coord;
    typedef logic signed [DW-1:0]   t_diff;
    typedef logic signed [PW-1:0]   t_prod;
    typedef logic        [PW-1:0]   t_sq;
    typedef logic signed [PPW-1:0]  t_pp;
    typedef logic signed [DETW-1:0] t_det;
    typedef logic signed [NW-1:0]   t_num;
    typedef logic        [NW-1:0]   t_unum;
    typedef logic        [RW-1:0]   t_rem;
    typedef logic        [QB-1:0]   t_quo;
    typedef logic signed [QW-1:0]   t_qs;
    typedef logic signed [SW-1:0]   t_sum;

    localparam t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // One division lane: partial remainder, quotient so far and the
    // numerator bits still to be brought down.
    typedef struct packed {
        t_rem rem;
        t_quo quo;
        t_quo num;
        logic neg;
        logic ovf;
    } t_div_lane;

    typedef struct packed {
        t_div_lane lx;
        t_div_lane ly;
        t_rem      ud;
        t_coord    ax;
        t_coord    ay;
        logic      dz;
    } t_div_item;

endpackage

### design/ccp_numer.sv
// Front end of the circumcentre pipeline: differences, squares, determinant,
// bisector numerators and divider set-up. Depends on ccp_pkg.
module ccp_numer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ccp_pkg::t_coord    i_ax,
    input  ccp_pkg::t_coord    i_ay,
    input  ccp_pkg::t_coord    i_bx,
    input  ccp_pkg::t_coord    i_by,
    input  ccp_pkg::t_coord    i_cx,
    input  ccp_pkg::t_coord    i_cy,
    output logic               o_valid,
    output ccp_pkg::t_div_item o_item
);
    import ccp_pkg::*;

    logic [7:0] r_v;

    // Stage 1
    t_coord r1_ax, r1_ay;
    t_diff  r1_bx, r1_by, r1_cx, r1_cy;
    // Stage 2
    t_coord r2_ax, r2_ay;
    t_diff  r2_bx, r2_by, r2_cx, r2_cy;
    t_prod  r2_bxx, r2_byy, r2_cxx, r2_cyy, r2_bxcy, r2_bycx;
    // Stage 3
    t_coord r3_ax, r3_ay;
    t_diff  r3_bx, r3_by, r3_cx, r3_cy;
    t_sq    r3_b2, r3_c2;
    t_det   r3_d;
    // Stage 4
    t_coord r4_ax, r4_ay;
    t_det   r4_d;
    t_pp    r4_cyb_lo, r4_cyb_hi, r4_byc_lo, r4_byc_hi;
    t_pp    r4_bxc_lo, r4_bxc_hi, r4_cxb_lo, r4_cxb_hi;
    // Stage 5
    t_coord r5_ax, r5_ay;
    t_det   r5_d;
    t_num   r5_p1, r5_p2, r5_p3, r5_p4;
    // Stage 6
    t_coord r6_ax, r6_ay;
    t_det   r6_d;
    t_num   r6_nx, r6_ny;
    // Stage 7
    t_coord r7_ax, r7_ay;
    t_unum  r7_unx, r7_uny;
    t_rem   r7_ud;
    logic   r7_negx, r7_negy, r7_dz;
    // Stage 8
    t_div_item r8_item;

    logic signed [DW:0] b2_lo, b2_hi, c2_lo, c2_hi;
    t_div_item n8_item;

    assign b2_lo = {1'b0, r3_b2[DW-1:0]};
    assign b2_hi = {1'b0, r3_b2[PW-1:DW]};
    assign c2_lo = {1'b0, r3_c2[DW-1:0]};
    assign c2_hi = {1'b0, r3_c2[PW-1:DW]};

    always_comb begin
        n8_item.ax    = r7_ax;
        n8_item.ay    = r7_ay;
        n8_item.ud    = r7_ud;
        n8_item.dz    = r7_dz;
        n8_item.lx.neg = r7_negx;
        n8_item.ly.neg = r7_negy;
        n8_item.lx.quo = '0;
        n8_item.ly.quo = '0;
        n8_item.lx.num = r7_unx[QB-1:0];
        n8_item.ly.num = r7_uny[QB-1:0];
        n8_item.lx.rem = RW'(r7_unx >> QB);
        n8_item.ly.rem = RW'(r7_uny >> QB);
        // A quotient that needs more than QB bits saturates whatever the offset.
        n8_item.lx.ovf = (RW+QB)'(r7_unx) >= {r7_ud, {QB{1'b0}}};
        n8_item.ly.ovf = (RW+QB)'(r7_uny) >= {r7_ud, {QB{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax <= i_ax;
            r1_ay <= i_ay;
            r1_bx <= DW'(i_bx) - DW'(i_ax);
            r1_by <= DW'(i_by) - DW'(i_ay);
            r1_cx <= DW'(i_cx) - DW'(i_ax);
            r1_cy <= DW'(i_cy) - DW'(i_ay);

            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_bxx  <= r1_bx * r1_bx;
            r2_byy  <= r1_by * r1_by;
            r2_cxx  <= r1_cx * r1_cx;
            r2_cyy  <= r1_cy * r1_cy;
            r2_bxcy <= r1_bx * r1_cy;
            r2_bycx <= r1_by * r1_cx;

            r3_ax <= r2_ax;
            r3_ay <= r2_ay;
            r3_bx <= r2_bx;
            r3_by <= r2_by;
            r3_cx <= r2_cx;
            r3_cy <= r2_cy;
            r3_b2 <= t_sq'(r2_bxx) + t_sq'(r2_byy);
            r3_c2 <= t_sq'(r2_cxx) + t_sq'(r2_cyy);
            r3_d  <= (DETW'(r2_bxcy) - DETW'(r2_bycx)) <<< 1;

            r4_ax     <= r3_ax;
            r4_ay     <= r3_ay;
            r4_d      <= r3_d;
            r4_cyb_lo <= r3_cy * b2_lo;
            r4_cyb_hi <= r3_cy * b2_hi;
            r4_byc_lo <= r3_by * c2_lo;
            r4_byc_hi <= r3_by * c2_hi;
            r4_bxc_lo <= r3_bx * c2_lo;
            r4_bxc_hi <= r3_bx * c2_hi;
            r4_cxb_lo <= r3_cx * b2_lo;
            r4_cxb_hi <= r3_cx * b2_hi;

            r5_ax <= r4_ax;
            r5_ay <= r4_ay;
            r5_d  <= r4_d;
            r5_p1 <= (NW'(r4_cyb_hi) <<< DW) + NW'(r4_cyb_lo);
            r5_p2 <= (NW'(r4_byc_hi) <<< DW) + NW'(r4_byc_lo);
            r5_p3 <= (NW'(r4_bxc_hi) <<< DW) + NW'(r4_bxc_lo);
            r5_p4 <= (NW'(r4_cxb_hi) <<< DW) + NW'(r4_cxb_lo);

            r6_ax <= r5_ax;
            r6_ay <= r5_ay;
            r6_d  <= r5_d;
            r6_nx <= r5_p1 - r5_p2;
            r6_ny <= r5_p3 - r5_p4;

            r7_ax   <= r6_ax;
            r7_ay   <= r6_ay;
            r7_unx  <= r6_nx[NW-1] ? t_unum'(-r6_nx) : t_unum'(r6_nx);
            r7_uny  <= r6_ny[NW-1] ? t_unum'(-r6_ny) : t_unum'(r6_ny);
            r7_ud   <= r6_d[DETW-1] ? t_rem'(-r6_d) : t_rem'(r6_d);
            r7_negx <= r6_nx[NW-1] ^ r6_d[DETW-1];
            r7_negy <= r6_ny[NW-1] ^ r6_d[DETW-1];
            r7_dz   <= (r6_d == '0);

            r8_item <= n8_item;
        end
    end

    assign o_valid = r_v[7];
    assign o_item  = r8_item;

endmodule

### design/ccp_div_step.sv
// One restoring-division step for both centre coordinates.
// Depends on ccp_pkg.
module ccp_div_step (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ccp_pkg::t_div_item i_item,
    output logic               o_valid,
    output ccp_pkg::t_div_item o_item
);
    import ccp_pkg::*;

    logic      r_valid;
    t_div_item r_item;
    t_div_item n_item;
    t_rem      trx, try_;
    logic      gex, gey;

    always_comb begin
        trx  = {i_item.lx.rem[RW-2:0], i_item.lx.num[QB-1]};
        try_ = {i_item.ly.rem[RW-2:0], i_item.ly.num[QB-1]};
        gex  = trx >= i_item.ud;
        gey  = try_ >= i_item.ud;
        n_item        = i_item;
        n_item.lx.rem = gex ? trx - i_item.ud : trx;
        n_item.ly.rem = gey ? try_ - i_item.ud : try_;
        n_item.lx.quo = {i_item.lx.quo[QB-2:0], gex};
        n_item.ly.quo = {i_item.ly.quo[QB-2:0], gey};
        n_item.lx.num = {i_item.lx.num[QB-2:0], 1'b0};
        n_item.ly.num = {i_item.ly.num[QB-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### design/ccp_finish.sv
// Back end: rounds the quotients, adds the first point, clamps and holds
// the result register. Depends on ccp_pkg.
module ccp_finish (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  ccp_pkg::t_div_item i_item,
    output logic               o_valid,
    output ccp_pkg::t_coord    o_center_x,
    output ccp_pkg::t_coord    o_center_y,
    output logic               o_valid_res,
    output logic               o_saturated
);
    import ccp_pkg::*;

    logic   r1_valid, r_valid;
    t_qs    r1_qx, r1_qy;
    logic   r1_ovfx, r1_ovfy, r1_dz;
    t_coord r1_ax, r1_ay;
    t_coord r_cx, r_cy;
    logic   r_vres, r_sat;

    t_qs    n1_qx, n1_qy;
    t_sum   sx, sy;
    t_coord n_cx, n_cy;
    logic   satx, saty;

    always_comb begin
        n1_qx = t_qs'(i_item.lx.quo)
              + t_qs'({i_item.lx.rem, 1'b0} >= {1'b0, i_item.ud});
        n1_qy = t_qs'(i_item.ly.quo)
              + t_qs'({i_item.ly.rem, 1'b0} >= {1'b0, i_item.ud});
        if (i_item.lx.neg) begin
            n1_qx = -n1_qx;
        end
        if (i_item.ly.neg) begin
            n1_qy = -n1_qy;
        end
    end

    always_comb begin
        sx = t_sum'(r1_ax) + t_sum'(r1_qx);
        sy = t_sum'(r1_ay) + t_sum'(r1_qy);
        satx = 1'b1;
        saty = 1'b1;
        if (r1_ovfx) begin
            n_cx = r1_qx[QW-1] ? COORD_MIN : COORD_MAX;
        end else if (sx > t_sum'(COORD_MAX)) begin
            n_cx = COORD_MAX;
        end else if (sx < t_sum'(COORD_MIN)) begin
            n_cx = COORD_MIN;
        end else begin
            n_cx = t_coord'(sx);
            satx = 1'b0;
        end
        if (r1_ovfy) begin
            n_cy = r1_qy[QW-1] ? COORD_MIN : COORD_MAX;
        end else if (sy > t_sum'(COORD_MAX)) begin
            n_cy = COORD_MAX;
        end else if (sy < t_sum'(COORD_MIN)) begin
            n_cy = COORD_MIN;
        end else begin
            n_cy = t_coord'(sy);
            saty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r_valid  <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r_valid  <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_qx   <= n1_qx;
            r1_qy   <= n1_qy;
            r1_ovfx <= i_item.lx.ovf;
            r1_ovfy <= i_item.ly.ovf;
            r1_dz   <= i_item.dz;
            r1_ax   <= i_item.ax;
            r1_ay   <= i_item.ay;
            r_cx    <= r1_dz ? '0 : n_cx;
            r_cy    <= r1_dz ? '0 : n_cy;
            r_vres  <= !r1_dz;
            r_sat   <= !r1_dz && (satx || saty);
        end
    end

    assign o_valid     = r_valid;
    assign o_center_x  = r_cx;
    assign o_center_y  = r_cy;
    assign o_valid_res = r_vres;
    assign o_saturated = r_sat;

endmodule

### design/circumcenter_three_points_core.sv
// Circumcentre of three points in the plane, fully pipelined: one transaction
// per clock in, one result transaction per clock out while the output is not
// stalled. From the input to the result register there are eight
// front stages (differences, squares, determinant, numerators split into
// 33x33 partial products, magnitudes and divider set-up), thirty-four
// restoring-division stages that each produce one quotient bit for both
// coordinates, and two stages for rounding, offset and clamping. The
// centre is the exact determinant solution rounded to nearest, ties away
// from zero, then clamped to the signed 32-bit coordinate range, in which
// case o_saturated is raised. Coincident or collinear points give
// o_valid_res low with zero centre and flag. The whole pipeline advances
// together; it halts only while a result is waiting at the output and the
// consumer holds i_stall, so o_stall follows that condition directly.
module circumcenter_three_points_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  ccp_pkg::t_coord i_first_x,
    input  ccp_pkg::t_coord i_first_y,
    input  ccp_pkg::t_coord i_second_x,
    input  ccp_pkg::t_coord i_second_y,
    input  ccp_pkg::t_coord i_third_x,
    input  ccp_pkg::t_coord i_third_y,
    output logic            o_valid,
    input  logic            i_stall,
    output ccp_pkg::t_coord o_center_x,
    output ccp_pkg::t_coord o_center_y,
    output logic            o_valid_res,
    output logic            o_saturated
);
    import ccp_pkg::*;

    // The pipeline moves whenever the result register is free or being taken.
    logic      en;
    logic      v_st [QB+1];
    t_div_item it_st [QB+1];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    ccp_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_ax    (i_first_x),
        .i_ay    (i_first_y),
        .i_bx    (i_second_x),
        .i_by    (i_second_y),
        .i_cx    (i_third_x),
        .i_cy    (i_third_y),
        .o_valid (v_st[0]),
        .o_item  (it_st[0])
    );

    // One division stage per quotient bit, most significant first.
    for (genvar k = 0; k < QB; k++) begin : g_div
        ccp_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_st[k]),
            .i_item  (it_st[k]),
            .o_valid (v_st[k+1]),
            .o_item  (it_st[k+1])
        );
    end

    ccp_finish u_finish (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (v_st[QB]),
        .i_item      (it_st[QB]),
        .o_valid     (o_valid),
        .o_center_x  (o_center_x),
        .o_center_y  (o_center_y),
        .o_valid_res (o_valid_res),
        .o_saturated (o_saturated)
    );

`ifndef NO_ASSERTIONS
    // A degenerate triple never carries a centre or a saturation flag.
    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_valid_res |-> o_center_x == '0 && o_center_y == '0 && !o_saturated)
        else $error("degenerate result carries data");

    // A saturated result has at least one coordinate at a range limit.
    a_sat_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_center_x == COORD_MAX || o_center_x == COORD_MIN
                                 || o_center_y == COORD_MAX || o_center_y == COORD_MIN)
        else $error("saturation flag without a clamped coordinate");

    // Reset empties the pipeline: no result in the cycle after it.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result presented straight after reset");

    // A transaction leaving the divider while the pipeline halts stays put.
    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en && v_st[QB] |=> v_st[QB] && $stable(it_st[QB]))
        else $error("divider output changed during a halt");
`endif

endmodule
